>>> hw/rtl/fpdp_pkg.sv
`default_nettype none
// ----------------------------------------------------------------------------
// fpdp_pkg
// Shared constants and helper functions for the fp16 dot-product engine.
// ----------------------------------------------------------------------------
package fpdp_pkg;

    localparam logic [1:0] CFG_ROWS    = 2'd0;
    localparam logic [1:0] CFG_COLS    = 2'd1;
    localparam logic [1:0] CFG_BIAS_EN = 2'd2;

    localparam logic [31:0] FP32_QNAN = 32'h7FC0_0000;
    localparam logic [31:0] FP32_ZERO = 32'h0000_0000;
    localparam logic [15:0] FP16_QNAN = 16'h7E00;
    localparam logic [14:0] FP16_INF  = 15'h7C00;

    // exact fp16 -> fp32 widening
    function automatic logic [31:0] half_to_float(input logic [15:0] h);
        logic [4:0]  ex;
        logic [9:0]  man;
        logic [3:0]  sh;
        logic        found;
        logic [9:0]  nman;
        logic [7:0]  e32;
        logic [31:0] res;
        ex    = h[14:10];
        man   = h[9:0];
        sh    = 4'd0;
        found = 1'b0;
        for (int i = 9; i >= 0; i--) begin
            if (!found && man[i]) begin
                found = 1'b1;
                sh    = 4'(10 - i);
            end
        end
        nman = man << sh;
        e32  = 8'd113 - {4'd0, sh};
        if (ex == 5'd31) begin
            res = {h[15], 8'hFF, man, 13'd0};
        end else if (ex == 5'd0) begin
            if (man == 10'd0) begin
                res = {h[15], 31'd0};
            end else begin
                res = {h[15], e32, nman, 13'd0};
            end
        end else begin
            res = {h[15], {3'd0, ex} + 8'd112, man, 13'd0};
        end
        return res;
    endfunction

    // leading zero count of a nonzero 27-bit word
    function automatic logic [4:0] lzc27(input logic [26:0] v);
        logic       found;
        logic [4:0] lz;
        found = 1'b0;
        lz    = 5'd0;
        for (int i = 0; i < 27; i++) begin
            if (!found && v[26-i]) begin
                found = 1'b1;
                lz    = 5'(i);
            end
        end
        return lz;
    endfunction

endpackage
`default_nettype wire

>>> hw/rtl/fp16_linear_dot_product.sv
`default_nettype none
// ----------------------------------------------------------------------------
// fp16_linear_dot_product
// Linear layer dot-product engine: fp16 pairs, fp32 accumulate, fp16 result.
// ----------------------------------------------------------------------------
// Takes one input beat per clock while the pipeline is not backed up from the
// master side. Each beat's exact product is added into the fp32 accumulator
// (that add-and-feedback loop sets the one-beat-per-cycle rate). A beat with
// tlast gives one result after it passes the input reg, product, accumulate,
// bias add and fp16 round stages, held in an output register; bubbles in the
// pipeline keep accepting beats while a result waits on the master side.
module fp16_linear_dot_product #(
    parameter int DIM_BITS = 16
) (
    input  wire  logic        i_clk,
    input  wire  logic        i_rst_n,
    input  wire  logic        i_s_tvalid,
    output logic              o_s_tready,
    input  wire  logic [47:0] i_s_tdata,  // in_value, weight_value, bias_value
    input  wire  logic        i_s_tlast,  // last_of_dot
    output logic              o_m_tvalid,
    input  wire  logic        i_m_tready,
    output logic [15:0]       o_m_tdata,  // result_value
    output logic              o_m_tlast,  // last_of_matrix
    input  wire  logic        i_cfg_we,
    input  wire  logic [1:0]  i_cfg_idx,
    input  wire  logic [15:0] i_cfg_data
);

    localparam int CW = (DIM_BITS + 1 > 17) ? DIM_BITS + 1 : 17;

    logic [15:0] r_rows, r_cols;
    logic        r_bias_en;

    logic        r_a_v, r_a_last;
    logic [15:0] r_a_in, r_a_wt, r_a_bias;
    logic        r_b_v, r_b_last;
    logic [31:0] r_b_prod;
    logic [15:0] r_b_bias;
    logic [31:0] r_acc;
    logic        r_c_v, r_c_lom;
    logic [31:0] r_c_sum;
    logic [15:0] r_c_bias;
    logic        r_d_v, r_d_lom;
    logic [31:0] r_d_tot;
    logic        r_o_v, r_o_lom;
    logic [15:0] r_o_data;

    logic [DIM_BITS-1:0] r_col, r_row;
    logic [DIM_BITS-1:0] n_col, n_row;

    logic        out_rdy, d_rdy, c_rdy, b_go, b_rdy, a_rdy;
    logic [31:0] prod, sum_b, tot_c;
    logic [15:0] half_d;
    logic [CW-1:0] cols_e, rows_e, col_p1, row_p1;
    logic        col_end, row_end;

    fpdp_mul u_mul (.i_a(r_a_in), .i_b(r_a_wt), .o_p(prod));
    fpdp_add u_acc_add (.i_a(r_acc), .i_b(r_b_prod), .o_y(sum_b));
    fpdp_add u_bias_add (
        .i_a(r_c_sum),
        .i_b(fpdp_pkg::half_to_float(r_c_bias)),
        .o_y(tot_c)
    );
    fpdp_cvt u_cvt (.i_f(r_d_tot), .o_h(half_d));

    assign out_rdy    = !r_o_v || i_m_tready;
    assign d_rdy      = !r_d_v || out_rdy;
    assign c_rdy      = !r_c_v || d_rdy;
    assign b_go       = r_b_v && (!r_b_last || c_rdy);
    assign b_rdy      = !r_b_v || b_go;
    assign a_rdy      = !r_a_v || b_rdy;
    assign o_s_tready = a_rdy;
    assign o_m_tvalid = r_o_v;
    assign o_m_tdata  = r_o_data;
    assign o_m_tlast  = r_o_lom;

    always_comb begin
        cols_e  = (r_cols == 16'd0) ? CW'(1) : CW'(r_cols);
        rows_e  = (r_rows == 16'd0) ? CW'(1) : CW'(r_rows);
        col_p1  = CW'(r_col) + CW'(1);
        row_p1  = CW'(r_row) + CW'(1);
        col_end = (col_p1 >= cols_e);
        row_end = (row_p1 >= rows_e);
        if (col_end) begin
            n_col = '0;
            n_row = row_end ? '0 : row_p1[DIM_BITS-1:0];
        end else begin
            n_col = col_p1[DIM_BITS-1:0];
            n_row = r_row;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_rows    <= 16'd1;
            r_cols    <= 16'd1;
            r_bias_en <= 1'b0;
        end else if (i_cfg_we) begin
            unique case (i_cfg_idx)
                fpdp_pkg::CFG_ROWS:    r_rows    <= i_cfg_data;
                fpdp_pkg::CFG_COLS:    r_cols    <= i_cfg_data;
                fpdp_pkg::CFG_BIAS_EN: r_bias_en <= i_cfg_data[0];
                default: ;
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_a_v <= 1'b0;
            r_b_v <= 1'b0;
            r_c_v <= 1'b0;
            r_d_v <= 1'b0;
            r_o_v <= 1'b0;
            r_acc <= fpdp_pkg::FP32_ZERO;
            r_col <= '0;
            r_row <= '0;
        end else begin
            if (a_rdy) begin
                r_a_v <= i_s_tvalid;
            end
            if (b_rdy) begin
                r_b_v <= r_a_v;
            end
            if (b_go) begin
                r_acc <= r_b_last ? fpdp_pkg::FP32_ZERO : sum_b;
            end
            if (c_rdy) begin
                r_c_v <= r_b_v && r_b_last;
            end
            if (r_b_v && r_b_last && c_rdy) begin
                r_col <= n_col;
                r_row <= n_row;
            end
            if (d_rdy) begin
                r_d_v <= r_c_v;
            end
            if (out_rdy) begin
                r_o_v <= r_d_v;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (a_rdy && i_s_tvalid) begin
            r_a_in   <= i_s_tdata[15:0];
            r_a_wt   <= i_s_tdata[31:16];
            r_a_bias <= i_s_tdata[47:32];
            r_a_last <= i_s_tlast;
        end
        if (b_rdy && r_a_v) begin
            r_b_prod <= prod;
            r_b_bias <= r_a_bias;
            r_b_last <= r_a_last;
        end
        if (c_rdy && r_b_v && r_b_last) begin
            r_c_sum  <= sum_b;
            r_c_bias <= r_b_bias;
            r_c_lom  <= col_end && row_end;
        end
        if (d_rdy && r_c_v) begin
            r_d_tot <= r_bias_en ? tot_c : r_c_sum;
            r_d_lom <= r_c_lom;
        end
        if (out_rdy && r_d_v) begin
            r_o_data <= half_d;
            r_o_lom  <= r_d_lom;
        end
    end

    a_acc_clear: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (b_go && r_b_last) |=> (r_acc == fpdp_pkg::FP32_ZERO))
        else $error("accumulator not cleared after dot product end");

    a_acc_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !r_b_v |=> $stable(r_acc))
        else $error("accumulator changed with no product in flight");

    a_stall_full: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !o_s_tready |-> (r_a_v && r_b_v && r_b_last && r_c_v && r_d_v && r_o_v))
        else $error("input stalled while pipeline has room");

    a_cnt_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !(r_b_v && r_b_last) |=> ($stable(r_col) && $stable(r_row)))
        else $error("index counters moved without a dot product end");

endmodule
`default_nettype wire

>>> hw/rtl/fpdp_mul.sv
`default_nettype none
// ----------------------------------------------------------------------------
// fpdp_mul
// Exact fp16 x fp16 product, delivered as fp32 (always representable).
// ----------------------------------------------------------------------------
module fpdp_mul (
    input  wire  logic [15:0] i_a,
    input  wire  logic [15:0] i_b,
    output logic [31:0]       o_p
);

    logic [31:0] fa, fb;
    logic        a_nan, b_nan, a_inf, b_inf, a_zero, b_zero, sgn;
    logic [21:0] sp;
    logic [8:0]  ep;
    logic [22:0] mp;

    always_comb begin
        fa     = fpdp_pkg::half_to_float(i_a);
        fb     = fpdp_pkg::half_to_float(i_b);
        a_nan  = (i_a[14:10] == 5'd31) && (i_a[9:0] != 10'd0);
        b_nan  = (i_b[14:10] == 5'd31) && (i_b[9:0] != 10'd0);
        a_inf  = (i_a[14:10] == 5'd31) && (i_a[9:0] == 10'd0);
        b_inf  = (i_b[14:10] == 5'd31) && (i_b[9:0] == 10'd0);
        a_zero = (i_a[14:0] == 15'd0);
        b_zero = (i_b[14:0] == 15'd0);
        sgn    = i_a[15] ^ i_b[15];
        sp     = {1'b1, fa[22:13]} * {1'b1, fb[22:13]};
        ep     = {1'b0, fa[30:23]} + {1'b0, fb[30:23]} - 9'd127 + {8'd0, sp[21]};
        mp     = sp[21] ? {sp[20:0], 2'd0} : {sp[19:0], 3'd0};
        if (a_nan || b_nan || (a_inf && b_zero) || (b_inf && a_zero)) begin
            o_p = fpdp_pkg::FP32_QNAN;
        end else if (a_inf || b_inf) begin
            o_p = {sgn, 8'hFF, 23'd0};
        end else if (a_zero || b_zero) begin
            o_p = {sgn, 31'd0};
        end else begin
            o_p = {sgn, ep[7:0], mp};
        end
    end

endmodule
`default_nettype wire

>>> hw/rtl/fpdp_add.sv
`default_nettype none
// ----------------------------------------------------------------------------
// fpdp_add
// fp32 adder, round to nearest even.
// ----------------------------------------------------------------------------
module fpdp_add (
    input  wire  logic [31:0] i_a,
    input  wire  logic [31:0] i_b,
    output logic [31:0]       o_y
);

    logic        a_nan, b_nan, a_inf, b_inf, a_big;
    logic [7:0]  ea, eb, xe, ye, d;
    logic [23:0] sa, sb, xm, ym;
    logic        xs, ys, sub, sticky, inc;
    logic [26:0] xext, yext, ysh, yal, norm;
    logic [27:0] sum;
    logic [4:0]  lz;
    logic signed [9:0] ex;
    logic [24:0] rnd;

    always_comb begin
        a_nan = (i_a[30:23] == 8'hFF) && (i_a[22:0] != 23'd0);
        b_nan = (i_b[30:23] == 8'hFF) && (i_b[22:0] != 23'd0);
        a_inf = (i_a[30:23] == 8'hFF) && (i_a[22:0] == 23'd0);
        b_inf = (i_b[30:23] == 8'hFF) && (i_b[22:0] == 23'd0);
        ea    = (i_a[30:23] == 8'd0) ? 8'd1 : i_a[30:23];
        eb    = (i_b[30:23] == 8'd0) ? 8'd1 : i_b[30:23];
        sa    = {(i_a[30:23] != 8'd0), i_a[22:0]};
        sb    = {(i_b[30:23] != 8'd0), i_b[22:0]};
        a_big = (i_a[30:0] >= i_b[30:0]);
        xs    = a_big ? i_a[31] : i_b[31];
        ys    = a_big ? i_b[31] : i_a[31];
        xe    = a_big ? ea : eb;
        ye    = a_big ? eb : ea;
        xm    = a_big ? sa : sb;
        ym    = a_big ? sb : sa;
        d     = xe - ye;
        xext  = {xm, 3'd0};
        yext  = {ym, 3'd0};
        if (d >= 8'd27) begin
            ysh    = 27'd0;
            sticky = (ym != 24'd0);
        end else begin
            ysh    = yext >> d;
            sticky = ((yext & ((27'd1 << d) - 27'd1)) != 27'd0);
        end
        yal  = {ysh[26:1], ysh[0] | sticky};
        sub  = xs ^ ys;
        sum  = sub ? ({1'b0, xext} - {1'b0, yal}) : ({1'b0, xext} + {1'b0, yal});
        lz   = fpdp_pkg::lzc27(sum[26:0]);
        if (sum[27]) begin
            norm = {sum[27:2], sum[1] | sum[0]};
            ex   = $signed({2'd0, xe}) + 10'sd1;
        end else begin
            norm = sum[26:0] << lz;
            ex   = $signed({2'd0, xe}) - $signed({5'd0, lz});
        end
        inc = norm[2] && ((norm[1] | norm[0]) || norm[3]);
        rnd = {1'b0, norm[26:3]} + {24'd0, inc};
        if (rnd[24]) begin
            ex = ex + 10'sd1;
        end

        if (a_nan || b_nan || (a_inf && b_inf && (i_a[31] != i_b[31]))) begin
            o_y = fpdp_pkg::FP32_QNAN;
        end else if (a_inf) begin
            o_y = i_a;
        end else if (b_inf) begin
            o_y = i_b;
        end else if (sum == 28'd0) begin
            o_y = {sub ? 1'b0 : xs, 31'd0};
        end else if (ex <= 10'sd0) begin
            o_y = {xs, 31'd0};
        end else if (ex >= 10'sd255) begin
            o_y = {xs, 8'hFF, 23'd0};
        end else begin
            o_y = {xs, ex[7:0], rnd[24] ? 23'd0 : rnd[22:0]};
        end
    end

endmodule
`default_nettype wire

>>> hw/rtl/fpdp_cvt.sv
`default_nettype none
// ----------------------------------------------------------------------------
// fpdp_cvt
// fp32 -> fp16 narrowing, round to nearest even, canonical NaN.
// ----------------------------------------------------------------------------
module fpdp_cvt (
    input  wire  logic [31:0] i_f,
    output logic [15:0]       o_h
);

    logic [7:0]  ex;
    logic [23:0] sig, keep, rem, half;
    logic signed [9:0] he;
    logic [4:0]  shift;
    logic [15:0] h;
    logic        sgn;

    always_comb begin
        sgn   = i_f[31];
        ex    = i_f[30:23];
        sig   = {1'b1, i_f[22:0]};
        he    = $signed({2'd0, ex}) - 10'sd112;
        shift = 5'(10'sd14 - he);
        keep  = 24'd0;
        rem   = 24'd0;
        half  = 24'd0;
        h     = 16'd0;
        if (ex == 8'hFF) begin
            o_h = (i_f[22:0] != 23'd0) ? fpdp_pkg::FP16_QNAN : {sgn, fpdp_pkg::FP16_INF};
        end else if (ex == 8'd0) begin
            o_h = {sgn, 15'd0};
        end else if (he >= 10'sd31) begin
            o_h = {sgn, fpdp_pkg::FP16_INF};
        end else if (he >= 10'sd1) begin
            keep = sig >> 13;
            rem  = {11'd0, sig[12:0]};
            h    = {1'b0, he[4:0], keep[9:0]};
            if ((rem > 24'h1000) || ((rem == 24'h1000) && keep[0])) begin
                h = h + 16'd1;
            end
            if (h >= {1'b0, fpdp_pkg::FP16_INF}) begin
                h = {1'b0, fpdp_pkg::FP16_INF};
            end
            o_h = {sgn, h[14:0]};
        end else if (he < -10'sd10) begin
            o_h = {sgn, 15'd0};
        end else begin
            keep = sig >> shift;
            rem  = sig & ((24'd1 << shift) - 24'd1);
            half = 24'd1 << (shift - 5'd1);
            h    = keep[15:0];
            if ((rem > half) || ((rem == half) && keep[0])) begin
                h = h + 16'd1;
            end
            o_h = {sgn, h[14:0]};
        end
    end

endmodule
`default_nettype wire
